### rtl/core/hmm_viterbi_decoder_top_defines.svh
// assertion macros used by the checker file
`ifndef HMM_VITERBI_DECODER_TOP_DEFINES_SVH
`define HMM_VITERBI_DECODER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define HVD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hvd check failed");

// next-cycle implication, off during reset
`define HVD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hvd check failed");

// next-cycle implication, checked during reset too
`define HVD_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("hvd check failed");

`endif

### rtl/core/hvd_pkg.sv
package hvd_pkg;

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int STATE_W = 7;
   localparam int SYM_W   = 11;
   localparam int SCORE_W = 32;
   localparam int POS_W   = 6;
   localparam int IDX_W   = 6;

   // item opcodes
   typedef enum logic [OP_W-1:0] {
      OP_INIT  = 2'd0,
      OP_TRANS = 2'd1,
      OP_EMIS  = 2'd2,
      OP_OBS   = 2'd3
   } opcode_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NOP      = 4'd0,
      CMD_LOAD     = 4'd1,
      CMD_INIT_RD  = 4'd2,
      CMD_ACS_RD   = 4'd3,
      CMD_PATH_WR  = 4'd4,
      CMD_BEST_RD  = 4'd5,
      CMD_SEED     = 4'd6,
      CMD_TRACE_RD = 4'd7,
      CMD_TRACE_WR = 4'd8,
      CMD_OUT_RD   = 4'd9,
      CMD_OUT_LOAD = 4'd10
   } cmd_kind_type;

   typedef struct packed {
      logic             take;
      cmd_kind_type     kind;
      logic [IDX_W-1:0] j;
      logic [IDX_W-1:0] k;
      logic [POS_W-1:0] pos;
      logic             half;
      logic             first;
      logic             from_init;
      logic             last_tag;
      logic             too_long;
   } cmd_type;

endpackage

### rtl/core/hvd_req_if.sv
interface hvd_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [6:0]                  row_state;
   logic [6:0]                  col_state;
   logic [10:0]                 symbol;
   logic signed [31:0]          score;
   logic                        last;

   modport source (output valid, opcode, row_state, col_state, symbol, score, last,
                   input ready);
   modport sink   (input valid, opcode, row_state, col_state, symbol, score, last,
                   output ready);
endinterface

### rtl/core/hvd_rsp_if.sv
interface hvd_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] position;
   logic [6:0] tag_state;
   logic       last_tag;
   logic       too_long;

   modport source (output valid, position, tag_state, last_tag, too_long, input ready);
   modport sink   (input valid, position, tag_state, last_tag, too_long, output ready);
endinterface

### rtl/core/hvd_csr_if.sv
interface hvd_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/core/hvd_ctrl.sv
module hvd_ctrl #(
   parameter int NUM_STATES = 64,
   parameter int MAX_LEN    = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [hvd_pkg::OP_W-1:0]     req_opcode,
   input  logic                         req_last,
   output logic                         req_ready,
   input  logic                         csr_valid,
   input  logic [hvd_pkg::STATE_W-1:0]  csr_data,
   output logic                         csr_ready,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output hvd_pkg::cmd_type             cmd
);

   localparam int SIW = $clog2(NUM_STATES);
   localparam int PW  = $clog2(MAX_LEN);
   localparam int CW  = $clog2(MAX_LEN + 1);
   localparam int SW7 = hvd_pkg::STATE_W;

   typedef enum logic [14:0] {
      S_IDLE       = 15'h0001,
      S_LOAD       = 15'h0002,
      S_OBS        = 15'h0004,
      S_INIT_RD    = 15'h0008,
      S_ACS_RD     = 15'h0010,
      S_ACS_WAIT   = 15'h0020,
      S_WR         = 15'h0040,
      S_BEST_RD    = 15'h0080,
      S_BEST_WAIT  = 15'h0100,
      S_SEED       = 15'h0200,
      S_TRACE_RD   = 15'h0400,
      S_TRACE_WAIT = 15'h0800,
      S_OUT_RD     = 15'h1000,
      S_OUT_LOAD   = 15'h2000,
      S_SPARE      = 15'h4000
   } state_type;

   state_type        state_ff, state_in;
   logic [SIW-1:0]   j_ff, j_in;
   logic [SIW-1:0]   k_ff, k_in;
   logic [PW-1:0]    i_ff, i_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             last_ff, last_in;
   logic [SW7-1:0]   n_ff, n_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             j_last, k_last, i_last, obs_full, rsp_free;
   logic [CW-1:0]    len_m1;

   assign j_last    = SW7'(j_ff) == (n_ff - SW7'(1));
   assign k_last    = SW7'(k_ff) == (n_ff - SW7'(1));
   assign len_m1    = cnt_ff - CW'(1);
   assign i_last    = CW'(i_ff) == len_m1;
   assign obs_full  = cnt_ff == CW'(MAX_LEN);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   // active state count, clamped to the built range
   always_comb begin
      n_in = n_ff;
      if (csr_valid) begin
         if (csr_data == '0) begin
            n_in = SW7'(1);
         end else if (csr_data > SW7'(NUM_STATES)) begin
            n_in = SW7'(NUM_STATES);
         end else begin
            n_in = csr_data;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.kind     = hvd_pkg::CMD_NOP;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               last_in  = req_last;
               state_in = (req_opcode == hvd_pkg::OP_OBS) ? S_OBS : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.kind = hvd_pkg::CMD_LOAD;
            state_in = S_IDLE;
         end
         S_OBS: begin
            j_in = '0;
            k_in = '0;
            if (!obs_full) begin
               state_in = (cnt_ff == '0) ? S_INIT_RD : S_ACS_RD;
            end else begin
               ovf_in   = 1'b1;
               state_in = last_ff ? S_BEST_RD : S_IDLE;
            end
         end
         S_INIT_RD: begin
            cmd.kind = hvd_pkg::CMD_INIT_RD;
            cmd.j    = hvd_pkg::IDX_W'(j_ff);
            state_in = S_WR;
         end
         S_ACS_RD: begin
            cmd.kind  = hvd_pkg::CMD_ACS_RD;
            cmd.j     = hvd_pkg::IDX_W'(j_ff);
            cmd.k     = hvd_pkg::IDX_W'(k_ff);
            cmd.first = k_ff == '0;
            cmd.half  = ~cnt_ff[0];
            k_in      = k_ff + SIW'(1);
            if (k_last) begin
               state_in = S_ACS_WAIT;
            end
         end
         S_ACS_WAIT: begin
            state_in = S_WR;
         end
         S_WR: begin
            cmd.kind      = hvd_pkg::CMD_PATH_WR;
            cmd.j         = hvd_pkg::IDX_W'(j_ff);
            cmd.pos       = hvd_pkg::POS_W'(cnt_ff);
            cmd.half      = cnt_ff[0];
            cmd.from_init = cnt_ff == '0;
            k_in          = '0;
            if (j_last) begin
               j_in     = '0;
               cnt_in   = cnt_ff + CW'(1);
               state_in = last_ff ? S_BEST_RD : S_IDLE;
            end else begin
               j_in     = j_ff + SIW'(1);
               state_in = (cnt_ff == '0) ? S_INIT_RD : S_ACS_RD;
            end
         end
         S_BEST_RD: begin
            cmd.kind  = hvd_pkg::CMD_BEST_RD;
            cmd.j     = hvd_pkg::IDX_W'(j_ff);
            cmd.first = j_ff == '0;
            cmd.half  = len_m1[0];
            j_in      = j_ff + SIW'(1);
            if (j_last) begin
               state_in = S_BEST_WAIT;
            end
         end
         S_BEST_WAIT: begin
            state_in = S_SEED;
         end
         S_SEED: begin
            cmd.kind = hvd_pkg::CMD_SEED;
            cmd.pos  = hvd_pkg::POS_W'(len_m1);
            i_in     = PW'(len_m1);
            state_in = (len_m1 == '0) ? S_OUT_RD : S_TRACE_RD;
         end
         S_TRACE_RD: begin
            cmd.kind = hvd_pkg::CMD_TRACE_RD;
            cmd.pos  = hvd_pkg::POS_W'(i_ff);
            state_in = S_TRACE_WAIT;
         end
         S_TRACE_WAIT: begin
            cmd.kind = hvd_pkg::CMD_TRACE_WR;
            cmd.pos  = hvd_pkg::POS_W'(i_ff - PW'(1));
            i_in     = i_ff - PW'(1);
            state_in = (i_ff == PW'(1)) ? S_OUT_RD : S_TRACE_RD;
         end
         S_OUT_RD: begin
            cmd.kind = hvd_pkg::CMD_OUT_RD;
            cmd.pos  = hvd_pkg::POS_W'(i_ff);
            state_in = S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            if (rsp_free) begin
               cmd.kind     = hvd_pkg::CMD_OUT_LOAD;
               cmd.pos      = hvd_pkg::POS_W'(i_ff);
               cmd.last_tag = i_last;
               cmd.too_long = ovf_ff;
               rsp_valid_in = 1'b1;
               if (i_last) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  i_in     = '0;
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + PW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         j_ff         <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         n_ff         <= SW7'(NUM_STATES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/hvd_datapath.sv
module hvd_datapath #(
   parameter int NUM_STATES  = 64,
   parameter int MAX_LEN     = 64,
   parameter int VOCAB       = 1024,
   parameter int SCORE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hvd_pkg::cmd_type                    cmd,
   input  logic [hvd_pkg::OP_W-1:0]            req_opcode,
   input  logic [hvd_pkg::STATE_W-1:0]         req_row_state,
   input  logic [hvd_pkg::STATE_W-1:0]         req_col_state,
   input  logic [hvd_pkg::SYM_W-1:0]           req_symbol,
   input  logic signed [hvd_pkg::SCORE_W-1:0]  req_score,
   output logic [hvd_pkg::POS_W-1:0]           rsp_position,
   output logic [hvd_pkg::STATE_W-1:0]         rsp_tag_state,
   output logic                                rsp_last_tag,
   output logic                                rsp_too_long
);

   localparam int SIW = $clog2(NUM_STATES);
   localparam int PW  = $clog2(MAX_LEN);
   localparam int VW  = $clog2(VOCAB);
   localparam int SW  = SCORE_WIDTH;
   localparam int EW  = (SW > hvd_pkg::SCORE_W) ? SW : hvd_pkg::SCORE_W;
   localparam int TW  = hvd_pkg::STATE_W;
   localparam int XW  = 17;

   localparam logic signed [SW-1:0] SFLOOR = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] SMAX   = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [EW-1:0] SFLOOR_E = EW'(SFLOOR);
   localparam logic signed [EW-1:0] SMAX_E   = EW'(SMAX);

   // saturating add, floor absorbs
   function automatic logic signed [SW-1:0] sadd(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
      logic signed [SW:0] s;
      s = {a[SW-1], a} + {b[SW-1], b};
      if (a == SFLOOR || b == SFLOOR) begin
         return SFLOOR;
      end else if (s[SW] != s[SW-1]) begin
         return s[SW] ? SFLOOR : SMAX;
      end else begin
         return s[SW-1:0];
      end
   endfunction

   // latched item
   logic [hvd_pkg::OP_W-1:0]           op_ff;
   logic [TW-1:0]                      row_ff, col_ff;
   logic [hvd_pkg::SYM_W-1:0]          sym_ff;
   logic signed [hvd_pkg::SCORE_W-1:0] score_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff    <= req_opcode;
         row_ff   <= req_row_state;
         col_ff   <= req_col_state;
         sym_ff   <= req_symbol;
         score_ff <= req_score;
      end
   end

   // field decode and load score saturation
   logic [TW-1:0]          row_m1, col_m1;
   logic [XW-1:0]          sym_m1;
   logic                   row_ok, col_ok, sym_ok;
   logic signed [EW-1:0]   sc_ext;
   logic signed [SW-1:0]   sc_sat;
   logic [SIW-1:0]         row_idx, col_idx, j_idx, k_idx;
   logic [VW-1:0]          sym_idx;
   logic [PW-1:0]          pos_idx;

   assign row_m1  = row_ff - TW'(1);
   assign col_m1  = col_ff - TW'(1);
   assign sym_m1  = XW'(sym_ff) - XW'(1);
   assign row_ok  = (row_ff != '0) && (row_ff <= TW'(NUM_STATES));
   assign col_ok  = (col_ff != '0) && (col_ff <= TW'(NUM_STATES));
   assign sym_ok  = (sym_ff != '0) && (XW'(sym_ff) <= XW'(VOCAB));
   assign row_idx = row_m1[SIW-1:0];
   assign col_idx = col_m1[SIW-1:0];
   assign sym_idx = sym_m1[VW-1:0];
   assign j_idx   = cmd.j[SIW-1:0];
   assign k_idx   = cmd.k[SIW-1:0];
   assign pos_idx = cmd.pos[PW-1:0];
   assign sc_ext  = EW'(score_ff);

   always_comb begin
      if (sc_ext > SMAX_E) begin
         sc_sat = SMAX;
      end else if (sc_ext < SFLOOR_E) begin
         sc_sat = SFLOOR;
      end else begin
         sc_sat = sc_ext[SW-1:0];
      end
   end

   logic is_load, ld_init, ld_trans, ld_emis;
   assign is_load  = cmd.kind == hvd_pkg::CMD_LOAD;
   assign ld_init  = is_load && (op_ff == hvd_pkg::OP_INIT) && row_ok;
   assign ld_trans = is_load && (op_ff == hvd_pkg::OP_TRANS) && row_ok && col_ok;
   assign ld_emis  = is_load && (op_ff == hvd_pkg::OP_EMIS) && row_ok && sym_ok;

   // score tables
   logic signed [SW-1:0] init_mem  [NUM_STATES];
   logic signed [SW-1:0] trans_mem [2**(2*SIW)];
   logic signed [SW-1:0] emis_mem  [2**(SIW+VW)];
   logic signed [SW-1:0] init_rd_ff, trans_rd_ff, emis_rd_ff;

   always_ff @(posedge clock) begin
      if (ld_init) begin
         init_mem[row_idx] <= sc_sat;
      end
      if (cmd.kind == hvd_pkg::CMD_INIT_RD) begin
         init_rd_ff <= init_mem[j_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (ld_trans) begin
         trans_mem[{row_idx, col_idx}] <= sc_sat;
      end
      if (cmd.kind == hvd_pkg::CMD_ACS_RD) begin
         trans_rd_ff <= trans_mem[{k_idx, j_idx}];
      end
   end

   always_ff @(posedge clock) begin
      if (ld_emis) begin
         emis_mem[{row_idx, sym_idx}] <= sc_sat;
      end
      if (cmd.kind == hvd_pkg::CMD_INIT_RD ||
          (cmd.kind == hvd_pkg::CMD_ACS_RD && cmd.first)) begin
         emis_rd_ff <= emis_mem[{j_idx, sym_idx}];
      end
   end

   // new path score for state j
   logic signed [SW-1:0] emis_val, path_src, path_new;
   logic signed [SW-1:0] acc_ff;
   logic [TW-1:0]        bp_ff;

   assign emis_val = (sym_ok && emis_rd_ff != '0) ? emis_rd_ff : SFLOOR;
   assign path_src = cmd.from_init ? init_rd_ff : acc_ff;
   assign path_new = sadd(path_src, emis_val);

   // path scores, two halves
   logic signed [SW-1:0] path_mem [2**(SIW+1)];
   logic signed [SW-1:0] path_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.kind == hvd_pkg::CMD_PATH_WR) begin
         path_mem[{cmd.half, j_idx}] <= path_new;
      end
      if (cmd.kind == hvd_pkg::CMD_ACS_RD) begin
         path_rd_ff <= path_mem[{cmd.half, k_idx}];
      end else if (cmd.kind == hvd_pkg::CMD_BEST_RD) begin
         path_rd_ff <= path_mem[{cmd.half, j_idx}];
      end
   end

   // compare stage, one candidate per cycle
   logic                  s1_acs_ff, s1_best_ff, s1_first_ff;
   logic [SIW-1:0]        s1_idx_ff;
   logic signed [SW-1:0]  cand, base;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_acs_ff  <= 1'b0;
         s1_best_ff <= 1'b0;
      end else begin
         s1_acs_ff  <= cmd.kind == hvd_pkg::CMD_ACS_RD;
         s1_best_ff <= cmd.kind == hvd_pkg::CMD_BEST_RD;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_idx_ff   <= (cmd.kind == hvd_pkg::CMD_ACS_RD) ? k_idx : j_idx;
   end

   assign cand = s1_acs_ff ? sadd(path_rd_ff, trans_rd_ff) : path_rd_ff;
   assign base = s1_first_ff ? SFLOOR : acc_ff;

   always_ff @(posedge clock) begin
      if (s1_acs_ff || s1_best_ff) begin
         if (cand > base) begin
            acc_ff <= cand;
            bp_ff  <= TW'(s1_idx_ff) + TW'(1);
         end else if (s1_first_ff) begin
            acc_ff <= SFLOOR;
            bp_ff  <= '0;
         end
      end
   end

   // back-pointers per position and state
   logic [TW-1:0]  bptr_mem [2**(PW+SIW)];
   logic [TW-1:0]  bptr_rd_ff;
   logic [TW-1:0]  cur_tag_ff, tag_m1, next_tag;

   assign tag_m1   = cur_tag_ff - TW'(1);
   assign next_tag = (cur_tag_ff != '0) ? bptr_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.kind == hvd_pkg::CMD_PATH_WR) begin
         bptr_mem[{pos_idx, j_idx}] <= bp_ff;
      end
      if (cmd.kind == hvd_pkg::CMD_TRACE_RD) begin
         bptr_rd_ff <= bptr_mem[{pos_idx, tag_m1[SIW-1:0]}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.kind == hvd_pkg::CMD_SEED) begin
         cur_tag_ff <= bp_ff;
      end else if (cmd.kind == hvd_pkg::CMD_TRACE_WR) begin
         cur_tag_ff <= next_tag;
      end
   end

   // decoded tags in sentence order
   logic [TW-1:0] tag_mem [MAX_LEN];
   logic [TW-1:0] tag_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.kind == hvd_pkg::CMD_SEED) begin
         tag_mem[pos_idx] <= bp_ff;
      end else if (cmd.kind == hvd_pkg::CMD_TRACE_WR) begin
         tag_mem[pos_idx] <= next_tag;
      end
      if (cmd.kind == hvd_pkg::CMD_OUT_RD) begin
         tag_rd_ff <= tag_mem[pos_idx];
      end
   end

   // result register
   logic [hvd_pkg::POS_W-1:0] pos_ff;
   logic [TW-1:0]             tag_ff;
   logic                      last_tag_ff, too_long_ff;

   always_ff @(posedge clock) begin
      if (cmd.kind == hvd_pkg::CMD_OUT_LOAD) begin
         pos_ff      <= cmd.pos;
         tag_ff      <= tag_rd_ff;
         last_tag_ff <= cmd.last_tag;
         too_long_ff <= cmd.too_long;
      end
   end

   assign rsp_position  = pos_ff;
   assign rsp_tag_state = tag_ff;
   assign rsp_last_tag  = last_tag_ff;
   assign rsp_too_long  = too_long_ff;

endmodule

### rtl/core/hmm_viterbi_decoder_top.sv
// channel   dir   port     carries
// request   in    req_ch   opcode, row_state, col_state, symbol, score, last
// result    out   rsp_ch   position, tag_state, last_tag, too_long
// control   in    csr_ch   active_states (always ready)
//
// states are scored one at a time, n = active_states, through the one path-score
// read port feeding a shared add-compare; the last observation then adds a
// best-state scan, the backtrace and the result readout
// synchronous reset clears control only; score tables hold garbage until loaded
// a stalled result holds in the output register while the next sequence may start
module hmm_viterbi_decoder_top #(
   parameter int NUM_STATES  = 64,
   parameter int MAX_LEN     = 64,
   parameter int VOCAB       = 1024,
   parameter int SCORE_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   hvd_req_if.sink    req_ch,
   hvd_rsp_if.source  rsp_ch,
   hvd_csr_if.sink    csr_ch
);

   hvd_pkg::cmd_type cmd;

   // sequencer
   hvd_ctrl #(
      .NUM_STATES (NUM_STATES),
      .MAX_LEN    (MAX_LEN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_last   (req_ch.last),
      .req_ready  (req_ch.ready),
      .csr_valid  (csr_ch.valid),
      .csr_data   (csr_ch.data),
      .csr_ready  (csr_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .cmd        (cmd)
   );

   // tables, add-compare and backtrace
   hvd_datapath #(
      .NUM_STATES  (NUM_STATES),
      .MAX_LEN     (MAX_LEN),
      .VOCAB       (VOCAB),
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_opcode    (req_ch.opcode),
      .req_row_state (req_ch.row_state),
      .req_col_state (req_ch.col_state),
      .req_symbol    (req_ch.symbol),
      .req_score     (req_ch.score),
      .rsp_position  (rsp_ch.position),
      .rsp_tag_state (rsp_ch.tag_state),
      .rsp_last_tag  (rsp_ch.last_tag),
      .rsp_too_long  (rsp_ch.too_long)
   );

endmodule

### rtl/core/hvd_checker.sv
`include "hmm_viterbi_decoder_top_defines.svh"

module hvd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_position,
   input logic [6:0] rsp_tag_state,
   input logic       rsp_last_tag,
   input logic       rsp_too_long
);

   // reset empties the result register
   `HVD_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // every accepted item drops ready in the following cycle
   `HVD_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready)

   // no new item while a sequence is still being read out
   `HVD_ASSERT_IMPL(a_no_take_mid_seq, rsp_valid && !rsp_last_tag, !req_ready)

   // a stalled result holds
   `HVD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_position) && $stable(rsp_tag_state) &&
      $stable(rsp_last_tag) && $stable(rsp_too_long))

endmodule

bind hmm_viterbi_decoder_top hvd_checker u_hvd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_position  (rsp_ch.position),
   .rsp_tag_state (rsp_ch.tag_state),
   .rsp_last_tag  (rsp_ch.last_tag),
   .rsp_too_long  (rsp_ch.too_long)
);
